// ===== sv/feedback_queue_process_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// feedback queue process scheduler assertion macros
// implication checks on the block's ports, same cycle and next cycle
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_QUEUE_PROCESS_SCHEDULER_ASSERT_SVH
`define FEEDBACK_QUEUE_PROCESS_SCHEDULER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FQS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler port check failed");

// antecedent implies consequent in the next cycle
`define FQS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler port check failed");

`endif

// ===== sv/fqs_pkg.sv =====
// ----------------------------------------------------------------------------
// fqs_pkg
// shared constants, codes and types of the feedback queue process scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package fqs_pkg;

  localparam int PROC_SLOTS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF  = 32;
  localparam int IOS_PER_PROC_DEF = 8;
  localparam int NUM_DEV          = 3;

  localparam logic [7:0] QUANTUM_RST = 8'd4;
  localparam logic [7:0] SAT_MAX     = 8'hFF;

  localparam logic [1:0] FUNC_ADD_PROC = 2'd0;
  localparam logic [1:0] FUNC_ADD_IO   = 2'd1;
  localparam logic [1:0] FUNC_TICK     = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_STEP = 2'd1;
  localparam logic [1:0] KIND_IO   = 2'd2;

  localparam logic [1:0] DEV_DISK = 2'd0;

  typedef struct packed {
    logic push;
    logic pop;
  } fqs_fifo_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fqs_fifo_st_t;

  typedef struct packed {
    logic [7:0] done;
    logic [7:0] len;
    logic [1:0] dev;
    logic [7:0] step;
  } fqs_ent_t;

endpackage

`default_nettype wire

// ===== sv/fqs_fifo.sv =====
// ----------------------------------------------------------------------------
// fqs_fifo
// queue with head pointer and count, head word held in a register
// ----------------------------------------------------------------------------
`default_nettype none

module fqs_fifo
  import fqs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int W     = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fqs_fifo_ctl_t ctl,
  input  wire logic [W-1:0]  din,
  output fqs_fifo_st_t       st,
  output logic [W-1:0]       head
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [W-1:0]  head_r_q;
  logic          push_ok, pop_ok;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ok = ctl.push && (count_r != CW'(DEPTH));
  assign pop_ok  = ctl.pop && (count_r != '0);

  always_comb begin
    head_nxt  = pop_ok ? wrap_inc(head_r) : head_r;
    tail_nxt  = push_ok ? wrap_inc(tail_r) : tail_r;
    count_nxt = count_r;
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail_r] <= din;
    end
    if (push_ok && (tail_r == head_nxt)) begin
      head_r_q <= din;
    end else begin
      head_r_q <= mem[head_nxt];
    end
  end

  assign head     = head_r_q;
  assign st.full  = (count_r == CW'(DEPTH));
  assign st.empty = (count_r == '0);

endmodule

`default_nettype wire

// ===== sv/feedback_queue_process_scheduler.sv =====
// ----------------------------------------------------------------------------
// feedback_queue_process_scheduler
// two-level round-robin process scheduler with three device queues
// ----------------------------------------------------------------------------
// One word is taken at a time; in_tready is high only while the sequencer is
// idle. A tick word does queue work and, unless every queue is empty, scans
// the listed I/O requests of the running process (the request list sits in a
// memory with one read port and is read one entry at a time), then checks
// each device queue (each head request is read from the same memory). The
// result waits in an output register; the last cycle of a word is held until
// that register is handed over or free, and the next word is taken after it.
// ----------------------------------------------------------------------------
`default_nettype none

module feedback_queue_process_scheduler
  import fqs_pkg::*;
#(
  parameter int PROC_SLOTS   = PROC_SLOTS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int IOS_PER_PROC = IOS_PER_PROC_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // proc_id, burst_length, io_at_step, io_device, io_length
  input  wire logic [1:0]  in_tuser,  // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata, // now, overflow, run_id, switched, all_idle,
                                      // io_progress_mask, io_done_mask
  output logic [1:0]       out_tuser, // run_kind
  input  wire logic        cfg_wen,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int PW     = $clog2(PROC_SLOTS);
  localparam int IW     = (IOS_PER_PROC > 1) ? $clog2(IOS_PER_PROC) : 1;
  localparam int CW     = $clog2(IOS_PER_PROC + 1);
  localparam int EW     = PW + IW;
  localparam int EDEPTH = PROC_SLOTS * (2 ** IW);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_ADD      = 13'b0000000000010,
    S_EXP      = 13'b0000000000100,
    S_DEMOTE   = 13'b0000000001000,
    S_SEL      = 13'b0000000010000,
    S_IDLECHK  = 13'b0000000100000,
    S_RUN      = 13'b0000001000000,
    S_SCAN_RD  = 13'b0000010000000,
    S_SCAN_CHK = 13'b0000100000000,
    S_RUNEND   = 13'b0001000000000,
    S_DEV      = 13'b0010000000000,
    S_DEV_CHK  = 13'b0100000000000,
    S_FIN      = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]    quantum_r;
  logic [31:0]   tick_r, tick_nxt, slice_r, slice_nxt;
  logic          rv_r, rv_nxt;
  logic [PW-1:0] rid_r, rid_nxt;
  logic          ovf_r, ovf_nxt, sw_r, sw_nxt, idle_r, idle_nxt, issued_r, issued_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [PW-1:0] orid_r, orid_nxt, p_r, p_nxt;
  logic [2:0]    pm_r, pm_nxt, dm_r, dm_nxt;
  logic [8:0]    step_r, step_nxt;
  logic [CW-1:0] n_r, n_nxt, i_r, i_nxt;
  logic [1:0]    d_r, d_nxt;
  logic [EW-1:0] ent_a_r, ent_a_nxt;

  logic [1:0]    func_r;
  logic [3:0]    pid_r;
  logic [7:0]    burst_r, ios_r, iol_r;
  logic [1:0]    iod_r;

  logic          out_valid_r;
  logic [47:0]   out_data_r;
  logic [1:0]    out_user_r;

  logic [7:0]    burst_tbl [PROC_SLOTS];
  logic [7:0]    prog_tbl  [PROC_SLOTS];
  logic [CW-1:0] cnt_tbl   [PROC_SLOTS];
  fqs_ent_t      ent_mem   [EDEPTH];
  logic [31:0]   itime_mem [EDEPTH];

  logic [PW-1:0] slot_a, tw_a, pid_slot, dev_slot;
  logic [7:0]    bt_rd, pt_rd;
  logic [CW-1:0] ct_rd;
  logic          bt_we, pt_we, ct_we;
  logic [7:0]    pt_wd;
  logic [CW-1:0] ct_wd;
  logic          ent_we, it_we;
  logic [EW-1:0] ent_wa;
  fqs_ent_t      ent_wd, ent_rd;
  logic [31:0]   it_rd;
  logic          pid_ok, expire, fin_go;
  logic [7:0]    done_inc;

  fqs_fifo_ctl_t hq_ctl, lq_ctl;
  fqs_fifo_ctl_t dq_ctl [NUM_DEV];
  fqs_fifo_st_t  hq_st, lq_st;
  fqs_fifo_st_t  dq_st  [NUM_DEV];
  logic [PW-1:0] hq_head, lq_head, hq_din, lq_din;
  logic [EW-1:0] dq_head [NUM_DEV];

  fqs_fifo #(.DEPTH(QUEUE_DEPTH), .W(PW)) u_hq (
    .clk(clk), .rst_n(rst_n), .ctl(hq_ctl), .din(hq_din), .st(hq_st), .head(hq_head)
  );

  fqs_fifo #(.DEPTH(QUEUE_DEPTH), .W(PW)) u_lq (
    .clk(clk), .rst_n(rst_n), .ctl(lq_ctl), .din(lq_din), .st(lq_st), .head(lq_head)
  );

  for (genvar g = 0; g < NUM_DEV; g++) begin : g_dq
    fqs_fifo #(.DEPTH(QUEUE_DEPTH), .W(EW)) u_dq (
      .clk(clk), .rst_n(rst_n), .ctl(dq_ctl[g]), .din(ent_a_r), .st(dq_st[g]),
      .head(dq_head[g])
    );
  end

  assign pid_slot = PW'(pid_r);
  assign pid_ok   = ({28'd0, pid_r} < 32'(PROC_SLOTS));
  assign dev_slot = ent_a_r[EW-1:IW];
  assign bt_rd    = burst_tbl[slot_a];
  assign pt_rd    = prog_tbl[slot_a];
  assign ct_rd    = cnt_tbl[slot_a];
  assign expire   = (bt_rd == pt_rd) || ((tick_r - slice_r) >= 32'(quantum_r));
  assign done_inc = (ent_rd.done == SAT_MAX) ? ent_rd.done : ent_rd.done + 8'd1;
  assign fin_go   = !out_valid_r || out_tready;
  assign hq_din   = (state_r == S_ADD) ? pid_slot : dev_slot;
  assign lq_din   = (state_r == S_DEMOTE) ? rid_r : dev_slot;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    tick_nxt   = tick_r;
    slice_nxt  = slice_r;
    rv_nxt     = rv_r;
    rid_nxt    = rid_r;
    ovf_nxt    = ovf_r;
    sw_nxt     = sw_r;
    idle_nxt   = idle_r;
    issued_nxt = issued_r;
    kind_nxt   = kind_r;
    orid_nxt   = orid_r;
    p_nxt      = p_r;
    pm_nxt     = pm_r;
    dm_nxt     = dm_r;
    step_nxt   = step_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    d_nxt      = d_r;
    ent_a_nxt  = ent_a_r;
    slot_a     = rid_r;
    tw_a       = pid_slot;
    bt_we      = 1'b0;
    pt_we      = 1'b0;
    pt_wd      = '0;
    ct_we      = 1'b0;
    ct_wd      = '0;
    ent_we     = 1'b0;
    ent_wa     = ent_a_r;
    ent_wd     = ent_rd;
    it_we      = 1'b0;
    hq_ctl     = '0;
    lq_ctl     = '0;
    for (int k = 0; k < NUM_DEV; k++) begin
      dq_ctl[k] = '0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ovf_nxt   = 1'b0;
          sw_nxt    = 1'b0;
          idle_nxt  = 1'b0;
          kind_nxt  = KIND_NONE;
          orid_nxt  = '0;
          pm_nxt    = '0;
          dm_nxt    = '0;
          state_nxt = (in_tuser == FUNC_TICK) ? S_EXP : S_ADD;
        end
      end
      S_ADD: begin
        slot_a = pid_slot;
        if (func_r == FUNC_ADD_PROC && pid_ok) begin
          bt_we       = 1'b1;
          pt_we       = 1'b1;
          ct_we       = 1'b1;
          hq_ctl.push = 1'b1;
          ovf_nxt     = hq_st.full;
        end else if (func_r == FUNC_ADD_IO && pid_ok) begin
          if (ct_rd >= CW'(IOS_PER_PROC)) begin
            ovf_nxt = 1'b1;
          end else begin
            ent_we = 1'b1;
            ent_wa = {pid_slot, ct_rd[IW-1:0]};
            ent_wd = '{done: 8'd0, len: iol_r, dev: iod_r, step: ios_r};
            ct_we  = 1'b1;
            ct_wd  = ct_rd + 1'b1;
          end
        end
        state_nxt = S_FIN;
      end
      S_EXP: begin
        if (rv_r && expire) begin
          if (!hq_st.empty && hq_head == rid_r) begin
            hq_ctl.pop = 1'b1;
          end else begin
            lq_ctl.pop = 1'b1;
          end
          rv_nxt    = 1'b0;
          state_nxt = S_DEMOTE;
        end else begin
          state_nxt = S_IDLECHK;
        end
      end
      S_DEMOTE: begin
        if (bt_rd > pt_rd) begin
          lq_ctl.push = 1'b1;
          ovf_nxt     = ovf_r | lq_st.full;
        end
        sw_nxt    = 1'b1;
        state_nxt = S_SEL;
      end
      S_SEL: begin
        if (!hq_st.empty) begin
          rid_nxt   = hq_head;
          rv_nxt    = 1'b1;
          slice_nxt = tick_r;
        end else if (!lq_st.empty) begin
          rid_nxt   = lq_head;
          rv_nxt    = 1'b1;
          slice_nxt = tick_r;
        end
        state_nxt = S_IDLECHK;
      end
      S_IDLECHK: begin
        if (hq_st.empty && lq_st.empty && dq_st[0].empty && dq_st[1].empty &&
            dq_st[2].empty) begin
          idle_nxt  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          if (!rv_r || (!hq_st.empty && hq_head != rid_r)) begin
            if (!hq_st.empty || !lq_st.empty) begin
              sw_nxt = 1'b1;
            end
            if (!hq_st.empty) begin
              rid_nxt   = hq_head;
              rv_nxt    = 1'b1;
              slice_nxt = tick_r;
            end else if (!lq_st.empty) begin
              rid_nxt   = lq_head;
              rv_nxt    = 1'b1;
              slice_nxt = tick_r;
            end
          end
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (rv_r) begin
          p_nxt      = rid_r;
          step_nxt   = {1'b0, pt_rd} + 9'd1;
          n_nxt      = (ct_rd > CW'(IOS_PER_PROC)) ? CW'(IOS_PER_PROC) : ct_rd;
          i_nxt      = '0;
          issued_nxt = 1'b0;
          state_nxt  = S_SCAN_RD;
        end else begin
          d_nxt     = '0;
          state_nxt = S_DEV;
        end
      end
      S_SCAN_RD: begin
        if (i_r < n_r) begin
          ent_a_nxt = {p_r, i_r[IW-1:0]};
          state_nxt = S_SCAN_CHK;
        end else begin
          state_nxt = S_RUNEND;
        end
      end
      S_SCAN_CHK: begin
        if ({1'b0, ent_rd.step} == step_r) begin
          it_we = 1'b1;
          if (!issued_r) begin
            if (!hq_st.empty && hq_head == p_r) begin
              hq_ctl.pop = 1'b1;
              rv_nxt     = 1'b0;
            end else if (!lq_st.empty && lq_head == p_r) begin
              lq_ctl.pop = 1'b1;
              rv_nxt     = 1'b0;
            end
          end
          issued_nxt = 1'b1;
          for (int k = 0; k < NUM_DEV; k++) begin
            if (ent_rd.dev == 2'(k)) begin
              dq_ctl[k].push = 1'b1;
              ovf_nxt        = ovf_r | dq_st[k].full;
            end
          end
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = S_SCAN_RD;
      end
      S_RUNEND: begin
        slot_a = p_r;
        tw_a   = p_r;
        if (pt_rd != SAT_MAX) begin
          pt_we = 1'b1;
          pt_wd = pt_rd + 8'd1;
        end
        kind_nxt  = issued_r ? KIND_IO : KIND_STEP;
        orid_nxt  = p_r;
        d_nxt     = '0;
        state_nxt = S_DEV;
      end
      S_DEV: begin
        if (d_r == 2'(NUM_DEV)) begin
          state_nxt = S_FIN;
        end else if (!dq_st[d_r].empty) begin
          ent_a_nxt = dq_head[d_r];
          state_nxt = S_DEV_CHK;
        end else begin
          d_nxt = d_r + 2'd1;
        end
      end
      S_DEV_CHK: begin
        slot_a = dev_slot;
        if (it_rd != tick_r) begin
          ent_we     = 1'b1;
          ent_wd     = ent_rd;
          ent_wd.done = done_inc;
          pm_nxt[d_r] = 1'b1;
          if (done_inc >= ent_rd.len) begin
            dq_ctl[d_r].pop = 1'b1;
            dm_nxt[d_r]     = 1'b1;
            if (pt_rd < bt_rd) begin
              if (d_r == DEV_DISK) begin
                lq_ctl.push = 1'b1;
                ovf_nxt     = ovf_r | lq_st.full;
              end else begin
                hq_ctl.push = 1'b1;
                ovf_nxt     = ovf_r | hq_st.full;
              end
            end
          end
        end
        d_nxt     = d_r + 2'd1;
        state_nxt = S_DEV;
      end
      S_FIN: begin
        if (fin_go) begin
          if (func_r == FUNC_TICK) begin
            tick_nxt = tick_r + 32'd1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      quantum_r <= QUANTUM_RST;
      tick_r    <= '0;
      slice_r   <= '1;
      rv_r      <= 1'b0;
      rid_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wen) begin
        quantum_r <= cfg_wdata;
      end
      tick_r  <= tick_nxt;
      slice_r <= slice_nxt;
      rv_r    <= rv_nxt;
      rid_r   <= rid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r    <= ovf_nxt;
    sw_r     <= sw_nxt;
    idle_r   <= idle_nxt;
    issued_r <= issued_nxt;
    kind_r   <= kind_nxt;
    orid_r   <= orid_nxt;
    p_r      <= p_nxt;
    pm_r     <= pm_nxt;
    dm_r     <= dm_nxt;
    step_r   <= step_nxt;
    n_r      <= n_nxt;
    i_r      <= i_nxt;
    d_r      <= d_nxt;
    ent_a_r  <= ent_a_nxt;
    if (in_tvalid && in_tready) begin
      func_r  <= in_tuser;
      pid_r   <= in_tdata[3:0];
      burst_r <= in_tdata[11:4];
      ios_r   <= in_tdata[19:12];
      iod_r   <= in_tdata[21:20];
      iol_r   <= in_tdata[29:22];
    end
  end

  // slot tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PROC_SLOTS; k++) begin
        cnt_tbl[k] <= '0;
      end
    end else if (ct_we) begin
      cnt_tbl[tw_a] <= ct_wd;
    end
    if (bt_we) begin
      burst_tbl[tw_a] <= burst_r;
    end
    if (pt_we) begin
      prog_tbl[tw_a] <= pt_wd;
    end
  end

  // request list and issue time memories
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    if (it_we) begin
      itime_mem[ent_a_r] <= tick_r;
    end
    ent_rd <= ent_mem[ent_a_nxt];
    it_rd  <= itime_mem[ent_a_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && fin_go) begin
      out_data_r <= {3'd0, dm_r, pm_r, idle_r, sw_r, 4'(orid_r), ovf_r, tick_r};
      out_user_r <= kind_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

// ===== sv/fqs_checker.sv =====
// ----------------------------------------------------------------------------
// fqs_checker
// port-level checks of the feedback queue process scheduler
// ----------------------------------------------------------------------------
`default_nettype none

`include "feedback_queue_process_scheduler_assert.svh"

module fqs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  `FQS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `FQS_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `FQS_ASSERT_NOW(a_idle_no_run, out_tvalid && out_tdata[38], out_tuser == 2'd0)
  `FQS_ASSERT_NOW(a_no_run_no_id, out_tvalid && out_tuser == 2'd0, out_tdata[36:33] == 4'd0)

endmodule

bind feedback_queue_process_scheduler fqs_checker u_fqs_checker (.*);

`default_nettype wire

// ===== verif/feedback_queue_process_scheduler_test.sv =====
// ----------------------------------------------------------------------------
// feedback_queue_process_scheduler_test
// Stimulus and prediction for the two-level process scheduler. The bench
// keeps its own model of the slot tables, ready queues and device queues.
// It predicts every result word in order and compares each field.
// The tests are directed cases, a full request list, a full ready queue and
// random process mixes under several quantum settings. Both stream sides
// idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module feedback_queue_process_scheduler_test;
  import fqs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int Q_HIGH = 0;
  localparam int Q_LOW  = 1;
  localparam int Q_DEV0 = 2;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    bit [31:0] now;
    bit        overflow;
    bit [1:0]  run_kind;
    bit [3:0]  run_id;
    bit        switched;
    bit        all_idle;
    bit [2:0]  progress_mask;
    bit [2:0]  done_mask;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // proc_id, burst_length, io_at_step, io_device, io_length
  logic [1:0]  in_tuser = '0;   // func
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [47:0] out_tdata;       // now, overflow, run_id, switched, all_idle,
                                // io_progress_mask, io_done_mask
  logic [1:0]  out_tuser;       // run_kind
  logic        cfg_wen = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  feedback_queue_process_scheduler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // scheduler model state
  bit [7:0]  quantum_m;
  bit [7:0]  burst_m [16];
  bit [7:0]  prog_m [16];
  bit [7:0]  ent_step [16][8];
  bit [1:0]  ent_dev [16][8];
  bit [7:0]  ent_len [16][8];
  bit [7:0]  ent_done [16][8];
  bit [31:0] issue_tick [16][8];
  int        req_count [16];
  bit [6:0]  q_item [5][32];
  int        q_head [5];
  int        q_cnt [5];
  bit [31:0] tick_m;
  bit [31:0] slice_m;
  bit        run_v;
  bit [3:0]  run_id_m;

  sched_result_t sched_results_due[$];
  int  errors = 0;
  int  cycles = 0;
  bit  idle_on = 1'b0;
  int  ready_wait = 0;

  function automatic bit q_push(int q, bit [6:0] v);
    if (q_cnt[q] >= 32) return 1'b0;
    q_item[q][(q_head[q] + q_cnt[q]) % 32] = v;
    q_cnt[q]++;
    return 1'b1;
  endfunction

  function automatic void q_pop(int q);
    if (q_cnt[q] == 0) return;
    q_head[q] = (q_head[q] + 1) % 32;
    q_cnt[q]--;
  endfunction

  function automatic bit [6:0] q_front(int q);
    return q_item[q][q_head[q]];
  endfunction

  function automatic void pick_next(bit [31:0] now);
    if (q_cnt[Q_HIGH] != 0) begin
      run_id_m = 4'(q_front(Q_HIGH));
      run_v = 1'b1;
      slice_m = now;
    end else if (q_cnt[Q_LOW] != 0) begin
      run_id_m = 4'(q_front(Q_LOW));
      run_v = 1'b1;
      slice_m = now;
    end
  endfunction

  function automatic void reset_model();
    quantum_m = QUANTUM_RST;
    foreach (req_count[i]) req_count[i] = 0;
    foreach (q_cnt[i]) begin
      q_cnt[i] = 0;
      q_head[i] = 0;
    end
    tick_m = '0;
    slice_m = '1;
    run_v = 1'b0;
    run_id_m = '0;
  endfunction

  function automatic sched_result_t schedule_tick();
    sched_result_t r;
    bit [31:0] now;
    bit [31:0] elapsed;
    bit [3:0]  p;
    bit [6:0]  ref_id;
    bit [2:0]  k;
    int        nxt;
    bit        issued;
    r = '{default: '0};
    now = tick_m;
    r.now = now;
    tick_m = now + 1;
    if (run_v) begin
      p = run_id_m;
      elapsed = now - slice_m;
      if (burst_m[p] == prog_m[p] || elapsed >= {24'd0, quantum_m}) begin
        if (q_cnt[Q_HIGH] != 0 && q_front(Q_HIGH) == 7'(p)) q_pop(Q_HIGH);
        else q_pop(Q_LOW);
        run_v = 1'b0;
        if (burst_m[p] > prog_m[p] && !q_push(Q_LOW, 7'(p))) r.overflow = 1'b1;
        r.switched = 1'b1;
        pick_next(now);
      end
    end
    if (q_cnt[0] == 0 && q_cnt[1] == 0 && q_cnt[2] == 0 && q_cnt[3] == 0 && q_cnt[4] == 0) begin
      r.all_idle = 1'b1;
      return r;
    end
    if (!run_v || (q_cnt[Q_HIGH] != 0 && q_front(Q_HIGH) != 7'(run_id_m))) begin
      if (q_cnt[Q_HIGH] != 0 || q_cnt[Q_LOW] != 0) r.switched = 1'b1;
      pick_next(now);
    end
    if (run_v) begin
      p = run_id_m;
      nxt = int'(prog_m[p]) + 1;
      issued = 1'b0;
      for (int i = 0; i < req_count[p]; i++) begin
        if (int'(ent_step[p][i]) != nxt) continue;
        issue_tick[p][i] = now;
        if (!issued) begin
          if (q_cnt[Q_HIGH] != 0 && q_front(Q_HIGH) == 7'(p)) begin
            q_pop(Q_HIGH);
            run_v = 1'b0;
          end else if (q_cnt[Q_LOW] != 0 && q_front(Q_LOW) == 7'(p)) begin
            q_pop(Q_LOW);
            run_v = 1'b0;
          end
        end
        issued = 1'b1;
        if (ent_dev[p][i] < NUM_DEV && !q_push(Q_DEV0 + int'(ent_dev[p][i]), {p, 3'(i)}))
          r.overflow = 1'b1;
      end
      if (prog_m[p] != SAT_MAX) prog_m[p]++;
      r.run_kind = issued ? KIND_IO : KIND_STEP;
      r.run_id = p;
    end
    for (int d = 0; d < NUM_DEV; d++) begin
      if (q_cnt[Q_DEV0 + d] == 0) continue;
      ref_id = q_front(Q_DEV0 + d);
      p = ref_id[6:3];
      k = ref_id[2:0];
      if (issue_tick[p][k] == now) continue;
      if (ent_done[p][k] != SAT_MAX) ent_done[p][k]++;
      r.progress_mask[d] = 1'b1;
      if (ent_done[p][k] >= ent_len[p][k]) begin
        q_pop(Q_DEV0 + d);
        r.done_mask[d] = 1'b1;
        if (prog_m[p] < burst_m[p] && !q_push(d == 0 ? Q_LOW : Q_HIGH, 7'(p)))
          r.overflow = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic sched_result_t schedule_word(bit [1:0] func, bit [3:0] pid, bit [7:0] blen,
                                                  bit [7:0] at_step, bit [1:0] dev,
                                                  bit [7:0] len);
    sched_result_t r;
    int c;
    if (func == FUNC_TICK) return schedule_tick();
    r = '{default: '0};
    r.now = tick_m;
    if (func == FUNC_ADD_PROC) begin
      burst_m[pid] = blen;
      prog_m[pid] = '0;
      req_count[pid] = 0;
      if (!q_push(Q_HIGH, 7'(pid))) r.overflow = 1'b1;
    end else if (func == FUNC_ADD_IO) begin
      c = req_count[pid];
      if (c >= IOS_PER_PROC_DEF) begin
        r.overflow = 1'b1;
      end else begin
        ent_step[pid][c] = at_step;
        ent_dev[pid][c] = dev;
        ent_len[pid][c] = len;
        ent_done[pid][c] = '0;
        req_count[pid] = c + 1;
      end
    end
    return r;
  endfunction

  task automatic send_word(bit [1:0] func, bit [3:0] pid, bit [7:0] blen, bit [7:0] at_step,
                           bit [1:0] dev, bit [7:0] len);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {2'b00, len, dev, at_step, blen, pid};
    do @(posedge clk); while (!in_tready);
    sched_results_due.push_back(schedule_word(func, pid, blen, at_step, dev, len));
  endtask

  task automatic add_proc(bit [3:0] pid, bit [7:0] blen);
    send_word(FUNC_ADD_PROC, pid, blen, 8'($urandom), 2'($urandom), 8'($urandom));
  endtask

  task automatic add_io(bit [3:0] pid, bit [7:0] at_step, bit [1:0] dev, bit [7:0] len);
    send_word(FUNC_ADD_IO, pid, 8'($urandom), at_step, dev, len);
  endtask

  task automatic ticks(int n);
    repeat (n) send_word(FUNC_TICK, 4'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                         8'($urandom));
  endtask

  task automatic write_quantum(bit [7:0] v);
    in_tvalid <= 1'b0;
    wait (sched_results_due.size() == 0);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    quantum_m = v;
  endtask

  task automatic test_directed();
    idle_on = 1'b0;
    add_proc(0, 3);
    add_io(0, 1, DEV_DISK, 1);
    add_io(0, 1, 2'd3, 0);
    add_proc(15, 255);
    add_io(15, 255, 2'd2, 255);
    add_io(15, 2, 2'd1, 0);
    add_proc(15, 2);
    add_io(15, 1, 2'd2, 2);
    add_proc(7, 4);
    send_word(FUNC_NOP, 4'hF, 8'hFF, 8'hFF, 2'd3, 8'hFF);
    ticks(15);
  endtask

  task automatic test_request_list_full();
    idle_on = 1'b1;
    add_proc(3, 5);
    for (int i = 0; i < 9; i++) add_io(3, 8'(i % 5 + 1), 2'(i % 3), 8'(i % 3));
    ticks(12);
  endtask

  task automatic test_ready_queue_full();
    write_quantum(8'd255);
    idle_on = 1'b0;
    for (int i = 0; i < 34; i++) add_proc(4'(i), 1);
    ticks(40);
  endtask

  task automatic random_mix(int n);
    int sent;
    int blen;
    int nio;
    bit [3:0] pid;
    sent = 0;
    while (sent < n) begin
      idle_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 19) == 0) begin
        send_word(2'($urandom), 4'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                  8'($urandom));
        sent++;
        continue;
      end
      pid = 4'($urandom);
      blen = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
      add_proc(pid, 8'(blen));
      nio = $urandom_range(0, 3);
      for (int i = 0; i < nio; i++) begin
        add_io(pid, 8'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, blen + 1)),
               2'(($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2)),
               8'(($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 6)));
      end
      blen = $urandom_range(1, 10);
      ticks(blen);
      sent += 1 + nio + blen;
    end
  endtask

  task automatic test_quantum_settings();
    write_quantum(8'd0);
    random_mix(85);
    write_quantum(8'd1);
    random_mix(85);
    write_quantum(8'd255);
    random_mix(85);
    write_quantum(8'($urandom_range(2, 254)));
    random_mix(85);
    write_quantum(QUANTUM_RST);
    random_mix(85);
  endtask

  task automatic check_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      errors++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    sched_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (sched_results_due.size() == 0) begin
        errors++;
        $display("%0t unexpected result word: expected none actual %0h/%0h",
                 $time, out_tdata, out_tuser);
      end else begin
        e = sched_results_due.pop_front();
        check_field("now", e.now, out_tdata[31:0]);
        check_field("overflow", e.overflow, out_tdata[32]);
        check_field("run_id", e.run_id, out_tdata[36:33]);
        check_field("switched", e.switched, out_tdata[37]);
        check_field("all_idle", e.all_idle, out_tdata[38]);
        check_field("io_progress_mask", e.progress_mask, out_tdata[41:39]);
        check_field("io_done_mask", e.done_mask, out_tdata[44:42]);
        check_field("run_kind", e.run_kind, out_tuser);
      end
      ready_wait = idle_on ? $urandom_range(0, 19) : 0;
      out_tready <= (ready_wait == 0);
    end else if (ready_wait > 0) begin
      ready_wait--;
      out_tready <= (ready_wait == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("feedback_queue_process_scheduler test failed");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_request_list_full();
    test_ready_queue_full();
    test_quantum_settings();
    in_tvalid <= 1'b0;
    wait (sched_results_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("feedback_queue_process_scheduler test passed");
    end else begin
      $display("feedback_queue_process_scheduler test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/fqs_pkg.sv
sv/fqs_fifo.sv
sv/feedback_queue_process_scheduler.sv
sv/fqs_checker.sv
verif/feedback_queue_process_scheduler_test.sv
